// ===== src/scm_pkg.sv =====
// shared types, codes and constants for the sound card mailbox and mixer
`default_nettype none
package scm_pkg;

  localparam int PAGE_COUNT_DEF = 16;

  // operation codes
  localparam logic [2:0] OP_HOST_RD  = 3'd0;
  localparam logic [2:0] OP_HOST_WR  = 3'd1;
  localparam logic [2:0] OP_PORT_IN  = 3'd2;
  localparam logic [2:0] OP_PORT_OUT = 3'd3;
  localparam logic [2:0] OP_MEM_RD   = 3'd4;
  localparam logic [2:0] OP_MEM_WR   = 3'd5;

  // host port numbers (low address byte)
  localparam logic [7:0] HOST_DATA_PORT = 8'hB3;
  localparam logic [7:0] HOST_STAT_PORT = 8'hBB;

  // card port numbers (low nibble)
  localparam logic [3:0] PORT_PAGE     = 4'h0;
  localparam logic [3:0] PORT_COMMAND  = 4'h1;
  localparam logic [3:0] PORT_DATA     = 4'h2;
  localparam logic [3:0] PORT_OUTPUT   = 4'h3;
  localparam logic [3:0] PORT_STATUS   = 4'h4;
  localparam logic [3:0] PORT_CLR_CMD  = 4'h5;
  localparam logic [3:0] PORT_VOL0     = 4'h6;
  localparam logic [3:0] PORT_VOL1     = 4'h7;
  localparam logic [3:0] PORT_VOL2     = 4'h8;
  localparam logic [3:0] PORT_VOL3     = 4'h9;
  localparam logic [3:0] PORT_STAT_PG  = 4'hA;
  localparam logic [3:0] PORT_STAT_VOL = 4'hB;

  localparam logic [7:0] STATUS_RESET = 8'h7E;
  localparam logic [7:0] FLOAT_BYTE   = 8'hFF;
  localparam logic [2:0] SAMPLE_WINDOW = 3'b011;  // addr[15:13] of 0x6000..0x7fff

  // memory banks (addr[15:14])
  localparam logic [1:0] BANK_ROM   = 2'd0;
  localparam logic [1:0] BANK_FIXED = 2'd1;
  localparam logic [1:0] BANK_LOW   = 2'd2;
  localparam logic [1:0] BANK_HIGH  = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } req_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        hit;
    logic [18:0] mem_addr;
    logic        mem_write_ok;
    logic [16:0] left_level;
    logic [16:0] right_level;
  } rsp_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       hit;
  } reply_t;

  typedef struct packed {
    logic [3:0][5:0] vol;
    logic [3:0][7:0] smp;
  } mix_t;

endpackage
`default_nettype wire

// ===== src/scm_ctrl.sv =====
// mailbox registers, card port decoder, volumes and sample latches
`default_nettype none
module scm_ctrl #(
  parameter int PAGE_COUNT = scm_pkg::PAGE_COUNT_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              step,
  input  scm_pkg::req_t                    item,
  output scm_pkg::reply_t                  reply,
  output scm_pkg::mix_t                    mix_next,
  output logic [$clog2(PAGE_COUNT)-1:0]    page
);
  import scm_pkg::*;

  localparam int PW = $clog2(PAGE_COUNT);

  logic [7:0]      command_reg, command_reg_next;
  logic [7:0]      status_reg, status_reg_next;
  logic [7:0]      data_reg, data_reg_next;
  logic [7:0]      output_reg, output_reg_next;
  logic [3:0][5:0] volume, volume_next;
  logic [3:0][7:0] sample, sample_next;
  logic [PW-1:0]   page_next;
  logic [7:0]      lo;
  logic [3:0]      nib;
  logic [3:0]      vol_off;
  logic [7:0]      stat_from_page, stat_from_vol;

  assign lo      = item.addr[7:0];
  assign nib     = item.addr[3:0];
  assign vol_off = nib - PORT_VOL0;

  assign stat_from_page = STATUS_RESET | {~page[0], 6'b0, status_reg[0]};
  assign stat_from_vol  = STATUS_RESET | {status_reg[7], 6'b0, volume[3][5]};

  always_comb begin
    command_reg_next = command_reg;
    status_reg_next  = status_reg;
    data_reg_next    = data_reg;
    output_reg_next  = output_reg;
    volume_next      = volume;
    sample_next      = sample;
    page_next        = page;
    reply            = '0;
    unique case (item.op)
      OP_HOST_RD: begin
        if (lo == HOST_DATA_PORT) begin
          reply.rdata     = output_reg;
          reply.hit       = 1'b1;
          status_reg_next = status_reg & 8'h7F;
        end else if (lo == HOST_STAT_PORT) begin
          reply.rdata = status_reg;
          reply.hit   = 1'b1;
        end else begin
          reply.rdata = FLOAT_BYTE;
        end
      end
      OP_HOST_WR: begin
        if (lo == HOST_DATA_PORT) begin
          data_reg_next   = item.wdata;
          status_reg_next = status_reg | 8'h80;
          reply.hit       = 1'b1;
        end else if (lo == HOST_STAT_PORT) begin
          command_reg_next = item.wdata;
          status_reg_next  = status_reg | 8'h01;
          reply.hit        = 1'b1;
        end
      end
      OP_PORT_IN: begin
        reply.hit   = 1'b1;
        reply.rdata = FLOAT_BYTE;
        unique case (nib)
          PORT_COMMAND:  reply.rdata = command_reg;
          PORT_DATA: begin
            reply.rdata     = data_reg;
            status_reg_next = status_reg & 8'h7F;
          end
          PORT_STATUS:   reply.rdata = status_reg;
          PORT_CLR_CMD:  status_reg_next = status_reg & 8'hFE;
          PORT_STAT_PG:  status_reg_next = stat_from_page;
          PORT_STAT_VOL: status_reg_next = stat_from_vol;
          default: ;
        endcase
      end
      OP_PORT_OUT: begin
        reply.hit = 1'b1;
        unique case (nib)
          PORT_PAGE: page_next = item.wdata[PW-1:0];
          PORT_OUTPUT: begin
            output_reg_next = item.wdata;
            status_reg_next = status_reg | 8'h80;
          end
          PORT_CLR_CMD:  status_reg_next = status_reg & 8'hFE;
          PORT_VOL0, PORT_VOL1, PORT_VOL2, PORT_VOL3:
            volume_next[vol_off[1:0]] = item.wdata[5:0];
          PORT_STAT_PG:  status_reg_next = stat_from_page;
          PORT_STAT_VOL: status_reg_next = stat_from_vol;
          default: ;
        endcase
      end
      OP_MEM_RD: begin
        reply.hit   = 1'b1;
        reply.rdata = item.wdata;
        // fetches in the sample window latch a channel sample
        if (item.addr[15:13] == SAMPLE_WINDOW) begin
          sample_next[item.addr[9:8]] = item.wdata;
        end
      end
      OP_MEM_WR: reply.hit = 1'b1;
      default: ;
    endcase
  end

  assign mix_next.vol = volume_next;
  assign mix_next.smp = sample_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_reg <= '0;
      status_reg  <= STATUS_RESET;
      data_reg    <= '0;
      output_reg  <= '0;
      volume      <= '0;
      sample      <= '0;
      page        <= '0;
    end else if (step) begin
      command_reg <= command_reg_next;
      status_reg  <= status_reg_next;
      data_reg    <= data_reg_next;
      output_reg  <= output_reg_next;
      volume      <= volume_next;
      sample      <= sample_next;
      page        <= page_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/scm_map.sv =====
// page map: physical card memory address and write permission
`default_nettype none
module scm_map #(
  parameter int PAGE_COUNT = scm_pkg::PAGE_COUNT_DEF
) (
  input  wire  [2:0]                    op,
  input  wire  [15:0]                   addr,
  input  wire  [$clog2(PAGE_COUNT)-1:0] page,
  output logic [18:0]                   mem_addr,
  output logic                          mem_write_ok
);
  import scm_pkg::*;

  localparam int PW = $clog2(PAGE_COUNT);

  logic [PW+3:0] page_ext;
  logic [18:0]   phys;
  logic          writable;
  logic          is_mem;

  // only the low four page bits survive the 19-bit wrap
  assign page_ext = {4'b0, page};
  assign is_mem   = (op == OP_MEM_RD) || (op == OP_MEM_WR);

  always_comb begin
    unique case (addr[15:14])
      BANK_ROM: begin
        phys     = {5'b0, addr[13:0]};
        writable = 1'b0;
      end
      BANK_FIXED: begin
        phys     = {4'b0001, 1'b1, addr[13:0]};
        writable = 1'b1;
      end
      BANK_LOW: begin
        phys     = {page_ext[3:0], 1'b0, addr[13:0]};
        writable = (page != '0);
      end
      BANK_HIGH: begin
        phys     = {page_ext[3:0], 1'b1, addr[13:0]};
        writable = (page != '0);
      end
      default: begin
        phys     = '0;
        writable = 1'b0;
      end
    endcase
  end

  assign mem_addr     = is_mem ? phys : '0;
  assign mem_write_ok = (op == OP_MEM_WR) && writable;

endmodule
`default_nettype wire

// ===== src/scm_mix.sv =====
// four-channel mixer: volume times sample, cross-fed left and right levels
`default_nettype none
module scm_mix (
  input  scm_pkg::mix_t mix,
  output logic [16:0]   left_level,
  output logic [16:0]   right_level
);
  import scm_pkg::*;

  logic [13:0] prod [4];
  logic [14:0] sum_l, sum_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = 14'(mix.vol[i]) * 14'(mix.smp[i]);
    end
  end

  assign sum_l = 15'(prod[0]) + 15'(prod[1]);
  assign sum_r = 15'(prod[2]) + 15'(prod[3]);

  assign left_level  = {1'b0, sum_l, 1'b0} + 17'(sum_r[14:4]);
  assign right_level = {1'b0, sum_r, 1'b0} + 17'(sum_l[14:4]);

endmodule
`default_nettype wire

// ===== src/sound_card_mailbox_and_mixer_core.sv =====
// path: an accepted transaction passes the input register, then the response register;
//   while a response is stalled, it and the transaction behind it wait
// throughput: one transaction per cycle while the output is not stalled, set by the single
//   pass from the input register through decode, page map and mixer into the response register
// reset: rst clears both valid flags and loads mailbox, volume, sample and
//   page registers with their reset values; status reads 0x7e afterwards
`default_nettype none
module sound_card_mailbox_and_mixer_core #(
  parameter int PAGE_COUNT = scm_pkg::PAGE_COUNT_DEF
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           req_valid,
  output logic          req_stall,
  input  scm_pkg::req_t req,
  output logic          rsp_valid,
  input  wire           rsp_stall,
  output scm_pkg::rsp_t rsp
);
  import scm_pkg::*;

  localparam int PW = $clog2(PAGE_COUNT);

  logic          s1_valid;
  req_t          s1_item;
  logic          out_free;
  logic          step;
  logic          accept;
  reply_t        reply;
  mix_t          mix_next;
  logic [PW-1:0] page;
  logic [18:0]   mem_addr;
  logic          mem_write_ok;
  logic [16:0]   left_level, right_level;
  rsp_t          rsp_next;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign step      = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;
  assign accept    = req_valid && !req_stall;

  scm_ctrl #(.PAGE_COUNT(PAGE_COUNT)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (s1_item),
    .reply    (reply),
    .mix_next (mix_next),
    .page     (page)
  );

  scm_map #(.PAGE_COUNT(PAGE_COUNT)) u_map (
    .op           (s1_item.op),
    .addr         (s1_item.addr),
    .page         (page),
    .mem_addr     (mem_addr),
    .mem_write_ok (mem_write_ok)
  );

  // levels reflect the state after this transaction's update
  scm_mix u_mix (
    .mix         (mix_next),
    .left_level  (left_level),
    .right_level (right_level)
  );

  always_comb begin
    rsp_next.rdata        = reply.rdata;
    rsp_next.hit          = reply.hit;
    rsp_next.mem_addr     = mem_addr;
    rsp_next.mem_write_ok = mem_write_ok;
    rsp_next.left_level   = left_level;
    rsp_next.right_level  = right_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (step) begin
        s1_valid <= 1'b0;
      end
      if (step) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= req;
    end
    if (step) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/scm_checker.sv =====
// port-level checks for the sound card mailbox and mixer core, with bind
`default_nettype none
module scm_checker (
  input wire           clk,
  input wire           rst,
  input wire           req_valid,
  input wire           req_stall,
  input wire           rsp_valid,
  input wire           rsp_stall,
  input scm_pkg::rsp_t rsp
);
  import scm_pkg::*;

  // no response is pending straight after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // an accepted transaction reaches the response register if the output keeps moving
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
    else $error("accepted transaction produced no response in two cycles");

  // write permission only comes with a handled access
  a_wok_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.mem_write_ok |-> rsp.hit && rsp.rdata == 8'h00)
    else $error("write permission on an unhandled access");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind sound_card_mailbox_and_mixer_core scm_checker u_scm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
